@@ rtl/i2cmbs_pkg.sv @@
// Shared types and constants of the I2C master bit sequencer.
`timescale 1ns / 1ps
`default_nettype none

package i2cmbs_pkg;

  // Request codes carried by req_type
  localparam logic [2:0] ReqStart   = 3'd0;
  localparam logic [2:0] ReqStop    = 3'd1;
  localparam logic [2:0] ReqWrite   = 3'd2;
  localparam logic [2:0] ReqWaitAck = 3'd3;
  localparam logic [2:0] ReqRead    = 3'd4;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgTicksPerUnit = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgAckPollLimit = 1'b1;

  // Register reset values
  localparam logic [15:0] TicksPerUnitReset = 16'd8;
  localparam logic [15:0] AckPollLimitReset = 16'd3000;

  // Configuration as seen by the sequencer
  typedef struct packed {
    logic [15:0] ticks_per_unit;
    logic [15:0] ack_poll_limit;
  } cfg_t;

  // Per-tick result of the sequencer
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_enable;
    logic       busy;
    logic       done;
    logic [7:0] read_data;
    logic       ack_failed;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/i2c_master_bit_sequencer.sv @@
// Top level of the I2C master bit sequencer: tick input stage and result stage.
`timescale 1ns / 1ps
`default_nettype none

// I2C master bit sequencer. Each transfer on the input channel is one tick of
// the bus timing and may carry a command (start, stop, write byte, wait for
// acknowledge, read byte with ack or nack) together with the sampled SDA level;
// each tick yields exactly one result transfer with the SCL level, the SDA
// latch and drive enable, busy, done, the read byte and the ack-failure flag.
// A tick is registered in the input stage, run through the single-tick phase
// logic and stored in the result register, from which its result is offered;
// one tick is taken in every cycle while the result side keeps up, and
// the input stage holds a tick only while the result register waits to be taken.
// Phase lengths are 8, 3 and 2 units of ticks_per_unit ticks. Configuration
// writes are always ready and must only be issued while the sequencer is idle.

module i2c_master_bit_sequencer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write channel
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [i2cmbs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [15:0]                    cfg_data_i,
  // tick input channel
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic                           cmd_valid_i,
  input  wire logic [2:0]                     req_type_i,
  input  wire logic [7:0]                     write_byte_i,
  input  wire logic                           send_ack_i,
  input  wire logic                           sda_sample_i,
  // result channel
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic                           scl_level_o,
  output      logic                           sda_level_o,
  output      logic                           sda_drive_enable_o,
  output      logic                           busy_res_o,
  output      logic                           done_res_o,
  output      logic [7:0]                     read_data_o,
  output      logic                           ack_failed_o
);

  i2cmbs_pkg::cfg_t cfg;
  i2cmbs_pkg::res_t res;
  i2cmbs_pkg::res_t res_q;

  logic       in_valid_q;
  logic       cmd_valid_q;
  logic [2:0] req_type_q;
  logic [7:0] write_byte_q;
  logic       send_ack_q;
  logic       sda_sample_q;
  logic       out_valid_q;
  logic       out_free;
  logic       step;
  logic       in_take;

  assign cfg_ready_o = 1'b1;

  i2cmbs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Handshake: process the held tick when the result register can take it
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  i2cmbs_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .cfg_i        (cfg),
    .cmd_valid_i  (cmd_valid_q),
    .req_type_i   (req_type_q),
    .write_byte_i (write_byte_q),
    .send_ack_i   (send_ack_q),
    .sda_sample_i (sda_sample_q),
    .res_o        (res)
  );

  // Track occupancy of the input and result stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the tick payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_valid_q  <= cmd_valid_i;
      req_type_q   <= req_type_i;
      write_byte_q <= write_byte_i;
      send_ack_q   <= send_ack_i;
      sda_sample_q <= sda_sample_i;
    end
  end

  // Hold the result
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign scl_level_o        = res_q.scl_level;
  assign sda_level_o        = res_q.sda_level;
  assign sda_drive_enable_o = res_q.sda_drive_enable;
  assign busy_res_o         = res_q.busy;
  assign done_res_o         = res_q.done;
  assign read_data_o        = res_q.read_data;
  assign ack_failed_o       = res_q.ack_failed;

  // A held tick stays until the result register frees up
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q)
    else $error("held tick lost");

  // A result stays while stalled and no tick overwrites it
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !step)
    else $error("result overwritten while stalled");

  // A done result is never busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.done |-> !res_q.busy)
    else $error("done while busy");

  // Read data and failure appear only with done
  a_flags_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.done |-> res_q.read_data == 8'd0 && !res_q.ack_failed)
    else $error("result flags without done");

endmodule

`default_nettype wire

@@ rtl/i2cmbs_cfg.sv @@
// Configuration register file of the I2C master bit sequencer.
`timescale 1ns / 1ps
`default_nettype none

module i2cmbs_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [i2cmbs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [15:0]                   cfg_data_i,
  output i2cmbs_pkg::cfg_t                   cfg_o
);

  logic [15:0] tpu_q;
  logic [15:0] poll_limit_q;

  // Take a register write on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q        <= i2cmbs_pkg::TicksPerUnitReset;
      poll_limit_q <= i2cmbs_pkg::AckPollLimitReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        i2cmbs_pkg::CfgTicksPerUnit: tpu_q        <= cfg_data_i;
        i2cmbs_pkg::CfgAckPollLimit: poll_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o.ticks_per_unit = tpu_q;
  assign cfg_o.ack_poll_limit = poll_limit_q;

endmodule

`default_nettype wire

@@ rtl/i2cmbs_seq.sv @@
// Bus phase sequencer: state registers and single-tick next-state logic.
`timescale 1ns / 1ps
`default_nettype none

module i2cmbs_seq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire i2cmbs_pkg::cfg_t cfg_i,
  input  wire logic             cmd_valid_i,
  input  wire logic [2:0]       req_type_i,
  input  wire logic [7:0]       write_byte_i,
  input  wire logic             send_ack_i,
  input  wire logic             sda_sample_i,
  output i2cmbs_pkg::res_t      res_o
);

  // Phase codes
  localparam logic [4:0] PhIdle    = 5'd0;
  localparam logic [4:0] PhStA     = 5'd1;
  localparam logic [4:0] PhStB     = 5'd2;
  localparam logic [4:0] PhStC     = 5'd3;
  localparam logic [4:0] PhStD     = 5'd4;
  localparam logic [4:0] PhSpA     = 5'd5;
  localparam logic [4:0] PhSpB     = 5'd6;
  localparam logic [4:0] PhSpC     = 5'd7;
  localparam logic [4:0] PhSpD     = 5'd8;
  localparam logic [4:0] PhWrSetup = 5'd9;
  localparam logic [4:0] PhWrData  = 5'd10;
  localparam logic [4:0] PhWrHigh  = 5'd11;
  localparam logic [4:0] PhWrLow   = 5'd12;
  localparam logic [4:0] PhAkRel   = 5'd13;
  localparam logic [4:0] PhAkHigh  = 5'd14;
  localparam logic [4:0] PhAkPoll  = 5'd15;
  localparam logic [4:0] PhRdLow   = 5'd16;
  localparam logic [4:0] PhRdHigh  = 5'd17;
  localparam logic [4:0] PhAcSetup = 5'd18;
  localparam logic [4:0] PhAcData  = 5'd19;
  localparam logic [4:0] PhAcHigh  = 5'd20;
  localparam logic [4:0] PhAcLow   = 5'd21;

  logic [4:0]  phase_q, phase_d;
  logic [3:0]  bit_idx_q, bit_idx_d;
  logic [7:0]  shift_q, shift_d;
  logic [19:0] delay_q, delay_d;
  logic [15:0] poll_q, poll_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        drv_q, drv_d;
  logic        ack_q, ack_d;

  logic        done;
  logic        failed;
  logic [7:0]  rd;
  logic [15:0] tpu_eff;
  logic [19:0] dly8, dly3, dly2;
  logic [3:0]  bit_inc;

  // Phase lengths in ticks: a zero unit counts as one tick
  assign tpu_eff = (cfg_i.ticks_per_unit == 16'd0) ? 16'd1 : cfg_i.ticks_per_unit;
  assign dly8    = {1'b0, tpu_eff, 3'b000};
  assign dly2    = {3'b000, tpu_eff, 1'b0};
  assign dly3    = dly2 + {4'd0, tpu_eff};
  assign bit_inc = bit_idx_q + 4'd1;

  // Work out one tick
  always_comb begin
    phase_d   = phase_q;
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    delay_d   = delay_q;
    poll_d    = poll_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    drv_d     = drv_q;
    ack_d     = ack_q;
    done      = 1'b0;
    failed    = 1'b0;
    rd        = 8'd0;

    if (phase_q == PhIdle) begin
      if (cmd_valid_i && (req_type_i <= i2cmbs_pkg::ReqRead)) begin
        bit_idx_d = 4'd0;
        poll_d    = 16'd0;
        ack_d     = 1'b0;
        case (req_type_i)
          i2cmbs_pkg::ReqStart: begin
            sda_d   = 1'b1;
            phase_d = PhStA;
            delay_d = dly8;
          end
          i2cmbs_pkg::ReqStop: begin
            scl_d   = 1'b0;
            phase_d = PhSpA;
            delay_d = dly8;
          end
          i2cmbs_pkg::ReqWrite: begin
            shift_d = write_byte_i;
            scl_d   = 1'b0;
            drv_d   = 1'b1;
            phase_d = PhWrSetup;
            delay_d = dly3;
          end
          i2cmbs_pkg::ReqWaitAck: begin
            sda_d   = 1'b1;
            drv_d   = 1'b0;
            phase_d = PhAkRel;
            delay_d = dly2;
          end
          default: begin
            shift_d = 8'd0;
            ack_d   = send_ack_i;
            drv_d   = 1'b0;
            scl_d   = 1'b0;
            phase_d = PhRdLow;
            delay_d = dly3;
          end
        endcase
      end
    end else if (phase_q == PhAkPoll) begin
      // Poll SDA while SCL is high; give up with a stop past the limit
      if (!sda_sample_i) begin
        scl_d = 1'b0;
        done  = 1'b1;
      end else if (poll_q >= cfg_i.ack_poll_limit) begin
        ack_d   = 1'b1;
        scl_d   = 1'b0;
        phase_d = PhSpA;
        delay_d = dly8;
      end else begin
        poll_d = poll_q + 16'd1;
      end
    end else if (delay_q > 20'd1) begin
      delay_d = delay_q - 20'd1;
    end else begin
      // End of phase: apply the pins of the next one
      case (phase_q)
        PhStA: begin
          scl_d = 1'b1; drv_d = 1'b1; phase_d = PhStB; delay_d = dly8;
        end
        PhStB: begin
          sda_d = 1'b0; phase_d = PhStC; delay_d = dly8;
        end
        PhStC: begin
          scl_d = 1'b0; phase_d = PhStD; delay_d = dly8;
        end
        PhStD: done = 1'b1;
        PhSpA: begin
          sda_d = 1'b0; drv_d = 1'b1; phase_d = PhSpB; delay_d = dly8;
        end
        PhSpB: begin
          scl_d = 1'b1; phase_d = PhSpC; delay_d = dly8;
        end
        PhSpC: begin
          sda_d = 1'b1; phase_d = PhSpD; delay_d = dly8;
        end
        PhSpD: begin
          failed = ack_q;
          done   = 1'b1;
        end
        PhWrSetup: begin
          sda_d   = shift_q[7];
          shift_d = {shift_q[6:0], 1'b0};
          phase_d = PhWrData;
          delay_d = dly3;
        end
        PhWrData: begin
          scl_d = 1'b1; phase_d = PhWrHigh; delay_d = dly3;
        end
        PhWrHigh: begin
          scl_d = 1'b0; phase_d = PhWrLow; delay_d = dly3;
        end
        PhWrLow: begin
          bit_idx_d = bit_inc;
          if (bit_inc[3]) begin
            done = 1'b1;
          end else begin
            sda_d   = shift_q[7];
            shift_d = {shift_q[6:0], 1'b0};
            phase_d = PhWrData;
            delay_d = dly3;
          end
        end
        PhAkRel: begin
          scl_d = 1'b1; phase_d = PhAkHigh; delay_d = dly2;
        end
        PhAkHigh: begin
          phase_d = PhAkPoll;
          delay_d = 20'd0;
          poll_d  = 16'd0;
        end
        PhRdLow: begin
          // Sample SDA as SCL rises
          scl_d   = 1'b1;
          shift_d = {shift_q[6:0], sda_sample_i};
          phase_d = PhRdHigh;
          delay_d = dly2;
        end
        PhRdHigh: begin
          bit_idx_d = bit_inc;
          scl_d     = 1'b0;
          if (!bit_inc[3]) begin
            phase_d = PhRdLow;
            delay_d = dly3;
          end else begin
            drv_d   = 1'b1;
            phase_d = PhAcSetup;
            delay_d = dly3;
          end
        end
        PhAcSetup: begin
          sda_d = ~ack_q; phase_d = PhAcData; delay_d = dly3;
        end
        PhAcData: begin
          scl_d = 1'b1; phase_d = PhAcHigh; delay_d = dly3;
        end
        PhAcHigh: begin
          scl_d = 1'b0; phase_d = PhAcLow; delay_d = dly3;
        end
        PhAcLow: begin
          rd   = shift_q;
          done = 1'b1;
        end
        default: done = 1'b1;
      endcase
    end

    if (done) begin
      phase_d = PhIdle;
      delay_d = 20'd0;
    end
  end

  // Advance the state on each processed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      bit_idx_q <= 4'd0;
      shift_q   <= 8'd0;
      delay_q   <= 20'd0;
      poll_q    <= 16'd0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      drv_q     <= 1'b1;
      ack_q     <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      bit_idx_q <= bit_idx_d;
      shift_q   <= shift_d;
      delay_q   <= delay_d;
      poll_q    <= poll_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      drv_q     <= drv_d;
      ack_q     <= ack_d;
    end
  end

  assign res_o.scl_level        = scl_d;
  assign res_o.sda_level        = sda_d;
  assign res_o.sda_drive_enable = drv_d;
  assign res_o.busy             = (phase_d != PhIdle);
  assign res_o.done             = done;
  assign res_o.read_data        = rd;
  assign res_o.ack_failed       = failed;

  // A finished command leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && done |=> phase_q == PhIdle)
    else $error("sequencer not idle after done");

  // The bit counter never runs past a full byte
  a_bit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_idx_q <= 4'd8)
    else $error("bit index past eight");

  // A timeout is only reported at the end of a stop
  a_fail_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed |-> phase_q == PhSpD && done)
    else $error("ack failure outside stop end");

endmodule

`default_nettype wire
